// ----- rtl/dssl_pkg.sv -----
// Shared types, constants and codes for the day schedule setpoint lookup.
`default_nettype none
package dssl_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int MIN_PER_HOUR    = 60;

  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int TEMP_W = 11;
  localparam int MODE_W = 3;
  localparam int DAY_W  = 3;
  localparam int WHEN_W = 11;   // 31*60+63 fits in 11 bits

  localparam logic [DAY_W-1:0] DAY_SUNDAY   = 3'd0;
  localparam logic [DAY_W-1:0] DAY_SATURDAY = 3'd6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [MODE_W-1:0] MODE_UNSPEC = '0;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_TEMP = 3'd0;
  localparam logic signed [TEMP_W-1:0] DEFAULT_TEMP_RST = 11'sd200;

  // front-to-back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [WHEN_W-1:0]        when;
    logic signed [TEMP_W-1:0] temp;
    logic [MODE_W-1:0]        mode;
  } slot_t;

  typedef struct packed {
    logic                     is_query;
    logic                     weekend;
    logic                     first_entry;
    logic                     time_known;
    logic [WHEN_W-1:0]        when;
    logic signed [TEMP_W-1:0] temp;
    logic [MODE_W-1:0]        mode;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LD_START,
    BK_LD_RD,
    BK_LD_CMP,
    BK_Q_START,
    BK_Q_LAST,
    BK_Q_CMP,
    BK_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/day_schedule_setpoint_lookup.sv -----
// Top level: front end, item queue, back end and configuration register.
// Query: the table is scanned one read per cycle, comparing 1..MAX_ENTRIES entries;
//   the scan is skipped when the time is unknown or the table is empty.
// Load: the back end shifts each later entry up (BK_LD_RD, BK_LD_CMP) before writing the new one;
//   when the table is full the entry is dropped.
// Items are handled one at a time in the back end; two more wait in the queue.
// Reset (synchronous, rst_n low): counts cleared, default setpoint 200, table memory not cleared.
`default_nettype none
module day_schedule_setpoint_lookup #(
  parameter int MAX_ENTRIES = dssl_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: first_entry, hour[5], minute[6], entry_temperature[11],
  //           entry_mode[3], week_day[3], time_known, zero pad[2]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [dssl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: cmd, table_select
  input  wire logic [dssl_pkg::IN_TUSER_W-1:0]  in_tuser,
  // out_tdata: target_temperature[11], target_mode[3], zero pad[2]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [dssl_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [dssl_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [dssl_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dssl_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  logic signed [dssl_pkg::TEMP_W-1:0] default_temp_r, default_temp_nxt;
  logic                               cfg_wr;

  dssl_pkg::item_t                    push_item, head_item;
  logic                               q_full, q_push, q_valid, q_pop;
  logic signed [dssl_pkg::TEMP_W-1:0] res_temp;
  logic [dssl_pkg::MODE_W-1:0]        res_mode;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready &
                      (cfg_paddr == dssl_pkg::REG_DEFAULT_TEMP);
  assign default_temp_nxt = cfg_wr ? cfg_pwdata[dssl_pkg::TEMP_W-1:0] : default_temp_r;
  assign cfg_prdata = {{(dssl_pkg::CFG_DATA_W - dssl_pkg::TEMP_W){default_temp_r[dssl_pkg::TEMP_W-1]}},
                       default_temp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_temp_r <= dssl_pkg::DEFAULT_TEMP_RST;
    end else begin
      default_temp_r <= default_temp_nxt;
    end
  end

  dssl_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  dssl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_item  (head_item)
  );

  dssl_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (head_item),
    .q_pop        (q_pop),
    .default_temp (default_temp_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_temp     (res_temp),
    .out_mode     (res_mode)
  );

  assign out_tdata = {2'b00, res_mode, res_temp};

endmodule
`default_nettype wire

// ----- rtl/dssl_front.sv -----
// Front end: takes input transfers, decodes them into queue items.
`default_nettype none
module dssl_front (
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dssl_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [dssl_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output dssl_pkg::item_t                      q_item
);

  logic                                cmd;
  logic                                table_select;
  logic [dssl_pkg::HOUR_W-1:0]         hour;
  logic [dssl_pkg::MIN_W-1:0]          minute;
  logic [dssl_pkg::DAY_W-1:0]          week_day;
  logic [dssl_pkg::WHEN_W-1:0]         hour_min;

  assign cmd          = in_tuser[0];
  assign table_select = in_tuser[1];
  assign hour         = in_tdata[5:1];
  assign minute       = in_tdata[11:6];
  assign week_day     = in_tdata[28:26];

  assign hour_min = dssl_pkg::WHEN_W'(hour) * dssl_pkg::WHEN_W'(dssl_pkg::MIN_PER_HOUR);

  always_comb begin
    q_item.is_query    = (cmd == dssl_pkg::CMD_QUERY);
    q_item.first_entry = in_tdata[0];
    q_item.time_known  = in_tdata[29];
    q_item.when        = hour_min + dssl_pkg::WHEN_W'(minute);
    q_item.temp        = in_tdata[22:12];
    q_item.mode        = in_tdata[25:23];
    // queries pick the table from the day, loads from the selector
    if (cmd == dssl_pkg::CMD_QUERY) begin
      q_item.weekend = (week_day == dssl_pkg::DAY_SUNDAY) ||
                       (week_day == dssl_pkg::DAY_SATURDAY);
    end else begin
      q_item.weekend = table_select;
    end
  end

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

endmodule
`default_nettype wire

// ----- rtl/dssl_queue.sv -----
// Short FIFO of decoded items between front end and back end.
`default_nettype none
module dssl_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire dssl_pkg::item_t push_item,
  output logic                 full,
  output logic                 head_valid,
  input  wire logic            pop,
  output dssl_pkg::item_t      head_item
);

  dssl_pkg::item_t                entry_r [dssl_pkg::Q_DEPTH];
  logic [dssl_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dssl_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dssl_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full       = (cnt_r == dssl_pkg::Q_CNT_W'(dssl_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = entry_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dssl_back.sv -----
// Back end: table memory, insertion-sort loads, scanning queries, output register.
`default_nettype none
module dssl_back #(
  parameter int MAX_ENTRIES = dssl_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  input  wire dssl_pkg::item_t                 q_item,
  output logic                                 q_pop,
  input  wire logic signed [dssl_pkg::TEMP_W-1:0] default_temp,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [dssl_pkg::TEMP_W-1:0]   out_temp,
  output logic [dssl_pkg::MODE_W-1:0]          out_mode
);

  localparam int IDX_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // both tables share one memory, table select in the address MSB
  dssl_pkg::slot_t             mem [MEM_DEPTH];
  dssl_pkg::slot_t             rdata_r;
  logic [ADDR_W-1:0]           raddr;
  logic                        we;
  logic [ADDR_W-1:0]           waddr;
  dssl_pkg::slot_t             wdata;

  dssl_pkg::back_state_t       state_r, state_nxt;
  dssl_pkg::item_t             item_r, item_nxt;
  logic [CNT_W-1:0]            j_r, j_nxt;
  logic [CNT_W-1:0]            cnt_r [2];
  logic [CNT_W-1:0]            cnt_nxt [2];
  logic [CNT_W-1:0]            cur_cnt;
  logic [CNT_W-1:0]            j_dec, j_inc, cnt_dec;
  logic signed [dssl_pkg::TEMP_W-1:0] acc_temp_r, acc_temp_nxt;
  logic [dssl_pkg::MODE_W-1:0] acc_mode_r, acc_mode_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [dssl_pkg::TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic [dssl_pkg::MODE_W-1:0] out_mode_r, out_mode_nxt;
  dssl_pkg::slot_t             new_slot;

  assign cur_cnt = cnt_r[item_r.weekend];
  assign j_dec   = j_r - 1'b1;
  assign j_inc   = j_r + 1'b1;
  assign cnt_dec = cur_cnt - 1'b1;

  assign new_slot.when = item_r.when;
  assign new_slot.temp = item_r.temp;
  assign new_slot.mode = item_r.mode;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    j_nxt         = j_r;
    cnt_nxt[0]    = cnt_r[0];
    cnt_nxt[1]    = cnt_r[1];
    acc_temp_nxt  = acc_temp_r;
    acc_mode_nxt  = acc_mode_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_temp_nxt  = out_temp_r;
    out_mode_nxt  = out_mode_r;
    q_pop         = 1'b0;
    raddr         = {item_r.weekend, j_r[IDX_W-1:0]};
    we            = 1'b0;
    waddr         = {item_r.weekend, j_r[IDX_W-1:0]};
    wdata         = new_slot;

    case (state_r)
      dssl_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          if (!q_item.is_query && q_item.first_entry) begin
            cnt_nxt[q_item.weekend] = '0;
          end
          state_nxt = q_item.is_query ? dssl_pkg::BK_Q_START : dssl_pkg::BK_LD_START;
        end
      end

      dssl_pkg::BK_LD_START: begin
        if (cur_cnt >= CNT_W'(MAX_ENTRIES)) begin
          state_nxt = dssl_pkg::BK_IDLE;   // table full: drop the entry
        end else begin
          j_nxt     = cur_cnt;
          state_nxt = dssl_pkg::BK_LD_RD;
        end
      end

      dssl_pkg::BK_LD_RD: begin
        if (j_r == '0) begin
          we                      = 1'b1;
          cnt_nxt[item_r.weekend] = cur_cnt + 1'b1;
          state_nxt               = dssl_pkg::BK_IDLE;
        end else begin
          raddr     = {item_r.weekend, j_dec[IDX_W-1:0]};
          state_nxt = dssl_pkg::BK_LD_CMP;
        end
      end

      dssl_pkg::BK_LD_CMP: begin
        // strict compare keeps equal times in load order
        we = 1'b1;
        if (rdata_r.when > item_r.when) begin
          wdata     = rdata_r;
          j_nxt     = j_dec;
          state_nxt = dssl_pkg::BK_LD_RD;
        end else begin
          cnt_nxt[item_r.weekend] = cur_cnt + 1'b1;
          state_nxt               = dssl_pkg::BK_IDLE;
        end
      end

      dssl_pkg::BK_Q_START: begin
        if (!item_r.time_known || cur_cnt == '0) begin
          acc_temp_nxt = default_temp;
          acc_mode_nxt = dssl_pkg::MODE_UNSPEC;
          state_nxt    = dssl_pkg::BK_OUT;
        end else begin
          raddr     = {item_r.weekend, cnt_dec[IDX_W-1:0]};
          state_nxt = dssl_pkg::BK_Q_LAST;
        end
      end

      dssl_pkg::BK_Q_LAST: begin
        // previous day's last entry seeds the result, then scan from the top
        acc_temp_nxt = rdata_r.temp;
        acc_mode_nxt = rdata_r.mode;
        j_nxt        = '0;
        raddr        = {item_r.weekend, {IDX_W{1'b0}}};
        state_nxt    = dssl_pkg::BK_Q_CMP;
      end

      dssl_pkg::BK_Q_CMP: begin
        if (rdata_r.when > item_r.when) begin
          state_nxt = dssl_pkg::BK_OUT;
        end else begin
          acc_temp_nxt = rdata_r.temp;
          if (rdata_r.mode != dssl_pkg::MODE_UNSPEC) begin
            acc_mode_nxt = rdata_r.mode;
          end
          if (j_inc == cur_cnt) begin
            state_nxt = dssl_pkg::BK_OUT;
          end else begin
            j_nxt = j_inc;
            raddr = {item_r.weekend, j_inc[IDX_W-1:0]};
          end
        end
      end

      dssl_pkg::BK_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_temp_nxt  = acc_temp_r;
          out_mode_nxt  = acc_mode_r;
          state_nxt     = dssl_pkg::BK_IDLE;
        end
      end

      default: begin
        state_nxt = dssl_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dssl_pkg::BK_IDLE;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r[0]    <= cnt_nxt[0];
      cnt_r[1]    <= cnt_nxt[1];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    j_r        <= j_nxt;
    acc_temp_r <= acc_temp_nxt;
    acc_mode_r <= acc_mode_nxt;
    out_temp_r <= out_temp_nxt;
    out_mode_r <= out_mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_valid = out_valid_r;
  assign out_temp  = out_temp_r;
  assign out_mode  = out_mode_r;

endmodule
`default_nettype wire

// ----- rtl/dssl_checker.sv -----
// Port-level checks for the setpoint lookup, bound to the top level.
`default_nettype none
module dssl_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [dssl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             cfg_psel,
  input wire logic                             cfg_penable,
  input wire logic                             cfg_pwrite,
  input wire logic [dssl_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input wire logic [dssl_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input wire logic [dssl_pkg::CFG_DATA_W-1:0]  cfg_prdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset leaves no stale result behind
  a_rst_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // written setpoint reads back in the low TEMP_W bits
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == dssl_pkg::REG_DEFAULT_TEMP)
    |=> cfg_prdata[dssl_pkg::TEMP_W-1:0] == $past(cfg_pwdata[dssl_pkg::TEMP_W-1:0]))
    else $error("default setpoint readback mismatch");

  a_cfg_sext: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_prdata[dssl_pkg::CFG_DATA_W-1:dssl_pkg::TEMP_W] == '0) ||
    (cfg_prdata[dssl_pkg::CFG_DATA_W-1:dssl_pkg::TEMP_W] == '1))
    else $error("default setpoint readback not sign extended");

endmodule

bind day_schedule_setpoint_lookup dssl_checker u_dssl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for the day schedule setpoint lookup: directed and random loads and queries.
`default_nettype none
module testbench;
  import dssl_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int unsigned IDLE_CYCLES = 150;   // covers a full-table insertion plus queued items
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned CFG_PHASE_ITEMS = 150;
  localparam longint unsigned TIMEOUT = 64'd5_000_000;

  typedef struct {
    logic                     cmd;
    logic                     table_sel;
    logic                     first;
    logic                     known;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic signed [TEMP_W-1:0] temp;
    logic [MODE_W-1:0]        mode;
    logic [DAY_W-1:0]         day;
  } sched_item_t;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [MODE_W-1:0]        mode;
  } setpoint_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  day_schedule_setpoint_lookup u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predicted block state: index 0 weekday, 1 weekend
  slot_t                    sched_tab [2][TABLE_DEPTH];
  int unsigned              sched_cnt [2];
  logic signed [TEMP_W-1:0] default_temp;
  setpoint_t                setpoint_q [$];

  int unsigned mismatch_count = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  bit hold_req = 1'b0;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [HOUR_W-1:0] rand_hour();
    if ($urandom_range(0, 99) < 85) return HOUR_W'($urandom_range(0, 23));
    return HOUR_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [MIN_W-1:0] rand_minute();
    if ($urandom_range(0, 99) < 85) return MIN_W'($urandom_range(0, 59));
    return MIN_W'($urandom_range(0, 63));
  endfunction

  function automatic logic signed [TEMP_W-1:0] rand_temp();
    int t;
    if ($urandom_range(0, 99) < 85) begin
      t = int'($urandom_range(0, 2000)) - 1000;
      return TEMP_W'(t);
    end
    return TEMP_W'($urandom);
  endfunction

  // unused fields carry random noise
  function automatic sched_item_t make_load(logic sel, logic first, logic [HOUR_W-1:0] hour,
                                            logic [MIN_W-1:0] minute,
                                            logic signed [TEMP_W-1:0] temp,
                                            logic [MODE_W-1:0] mode);
    sched_item_t it;
    it.cmd = CMD_LOAD;
    it.table_sel = sel;
    it.first = first;
    it.hour = hour;
    it.minute = minute;
    it.temp = temp;
    it.mode = mode;
    it.day = DAY_W'($urandom);
    it.known = 1'($urandom);
    return it;
  endfunction

  function automatic sched_item_t make_query(logic [DAY_W-1:0] day, logic [HOUR_W-1:0] hour,
                                             logic [MIN_W-1:0] minute, logic known);
    sched_item_t it;
    it.cmd = CMD_QUERY;
    it.table_sel = 1'($urandom);
    it.first = 1'($urandom);
    it.hour = hour;
    it.minute = minute;
    it.temp = TEMP_W'($urandom);
    it.mode = MODE_W'($urandom);
    it.day = day;
    it.known = known;
    return it;
  endfunction

  function automatic sched_item_t rand_query();
    return make_query(DAY_W'($urandom_range(0, 7)), rand_hour(), rand_minute(),
                      $urandom_range(0, 9) != 0);
  endfunction

  function automatic sched_item_t rand_load(logic sel, logic first);
    return make_load(sel, first, rand_hour(), rand_minute(), rand_temp(),
                     MODE_W'($urandom_range(0, 7)));
  endfunction

  // updates the predicted tables; a query pushes its expected setpoint
  task automatic schedule_apply(input sched_item_t it);
    logic [WHEN_W-1:0] now;
    int unsigned idx, j, cnt;
    setpoint_t res;
    now = WHEN_W'(it.hour) * WHEN_W'(MIN_PER_HOUR) + WHEN_W'(it.minute);
    if (it.cmd == CMD_LOAD) begin
      idx = it.table_sel;
      if (it.first) sched_cnt[idx] = 0;
      if (sched_cnt[idx] < TABLE_DEPTH) begin
        j = sched_cnt[idx];
        // stable: a new entry goes after equal minutes
        while (j > 0 && sched_tab[idx][j-1].when > now) begin
          sched_tab[idx][j] = sched_tab[idx][j-1];
          j--;
        end
        sched_tab[idx][j].when = now;
        sched_tab[idx][j].temp = it.temp;
        sched_tab[idx][j].mode = it.mode;
        sched_cnt[idx]++;
      end
    end else begin
      idx = (it.day == DAY_SUNDAY || it.day == DAY_SATURDAY) ? 1 : 0;
      cnt = sched_cnt[idx];
      res.temp = default_temp;
      res.mode = MODE_UNSPEC;
      if (it.known && cnt > 0) begin
        // before the first entry the previous day's last entry applies
        res.temp = sched_tab[idx][cnt-1].temp;
        res.mode = sched_tab[idx][cnt-1].mode;
        for (j = 0; j < cnt; j++) begin
          if (sched_tab[idx][j].when > now) break;
          res.temp = sched_tab[idx][j].temp;
          if (sched_tab[idx][j].mode != MODE_UNSPEC) res.mode = sched_tab[idx][j].mode;
        end
      end
      setpoint_q.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string what, input int exp_val, input int act_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0s: expected %0d, got %0d", what, exp_val, act_val);
  endtask

  // starts and ends at a falling edge; tvalid stays high after the transfer
  task automatic send_item(input sched_item_t it);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, it.known, it.day, it.mode, it.temp, it.minute, it.hour, it.first};
    in_tuser <= {it.table_sel, it.cmd};
    do @(posedge clk); while (!in_tready);
    schedule_apply(it);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    wait (setpoint_q.size() == 0);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  // write, then read back the register
  task automatic write_default_temp(input logic signed [TEMP_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_DEFAULT_TEMP;
    cfg_pwdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    default_temp = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[TEMP_W-1:0] !== value)
      report_mismatch("default_temperature readback", value, $signed(cfg_prdata[TEMP_W-1:0]));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_empty_tables();
    send_item(make_query(3'd3, 5'd12, 6'd0, 1'b1));
    send_item(make_query(DAY_SUNDAY, 5'd0, 6'd0, 1'b1));
    send_item(make_query(DAY_SATURDAY, 5'd23, 6'd59, 1'b0));
    send_item(make_query(3'd7, 5'd31, 6'd63, 1'b1));
  endtask

  task automatic test_sorted_lookup();
    send_item(make_load(1'b0, 1'b1, 5'd12, 6'd0, 11'sd215, 3'd1));
    send_item(make_load(1'b0, 1'b0, 5'd6, 6'd30, -11'sd1000, 3'd2));
    // same minute as an earlier entry, mode left unspecified
    send_item(make_load(1'b0, 1'b0, 5'd12, 6'd0, 11'sd1000, MODE_UNSPEC));
    send_item(make_load(1'b0, 1'b0, 5'd22, 6'd15, -11'sd1, MODE_UNSPEC));
    send_item(make_load(1'b1, 1'b1, 5'd31, 6'd63, 11'sd0, 3'd7));
    // a second first entry clears the weekend table
    send_item(make_load(1'b1, 1'b1, 5'd0, 6'd0, 11'sd180, 3'd3));
    send_item(make_load(1'b1, 1'b0, 5'd18, 6'd45, 11'sh3FF, MODE_UNSPEC));
    send_item(make_query(3'd3, 5'd6, 6'd29, 1'b1));
    send_item(make_query(3'd1, 5'd6, 6'd30, 1'b1));
    send_item(make_query(3'd2, 5'd12, 6'd0, 1'b1));
    send_item(make_query(3'd5, 5'd23, 6'd59, 1'b1));
    send_item(make_query(DAY_SATURDAY, 5'd23, 6'd59, 1'b1));
    send_item(make_query(DAY_SUNDAY, 5'd0, 6'd0, 1'b1));
    send_item(make_query(3'd7, 5'd12, 6'd0, 1'b1));
    send_item(make_query(3'd4, 5'd31, 6'd63, 1'b0));
  endtask

  task automatic test_default_setpoint();
    logic signed [TEMP_W-1:0] values [4];
    values = '{-11'sd1000, 11'sd1000, 11'sd0, -11'sd1024};
    foreach (values[i]) begin
      wait_idle();
      write_default_temp(values[i]);
      send_item(make_query(DAY_W'($urandom_range(0, 7)), rand_hour(), rand_minute(), 1'b0));
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_item(rand_query());
    send_item(rand_load(1'b0, 1'b0));
    repeat (4) send_item(rand_query());
  endtask

  task automatic test_random_traffic();
    int unsigned sent, next_cfg, kind, len, fills, k;
    logic sel;
    sent = 0;
    fills = 0;
    next_cfg = CFG_PHASE_ITEMS;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_cfg) begin
        wait_idle();
        write_default_temp(rand_temp());
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_stalls = $urandom_range(0, 2) != 0;
        next_cfg += CFG_PHASE_ITEMS;
      end
      kind = (fills < 2) ? 0 : $urandom_range(0, 99);
      if (kind < 55) begin
        // reload a table, overfilling both at least once, then look it up
        sel = (fills < 2) ? fills[0] : 1'($urandom);
        len = (fills < 2) ? TABLE_DEPTH + 4 : $urandom_range(1, TABLE_DEPTH + 4);
        fills++;
        for (k = 0; k < len; k++) send_item(rand_load(sel, k == 0));
        sent += len;
        len = $urandom_range(1, 8);
        repeat (len) send_item(rand_query());
        sent += len;
      end else if (kind < 85) begin
        len = $urandom_range(1, 10);
        repeat (len) send_item(rand_query());
        sent += len;
      end else begin
        send_item(rand_load(1'($urandom), $urandom_range(0, 3) == 0));
        sent++;
      end
    end
  endtask

  // result receiver: stretches of ready, random stalls, one long hold-off
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    setpoint_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (setpoint_q.size() == 0) begin
        report_mismatch("unexpected result, temperature", 0,
                        $signed(out_tdata[TEMP_W-1:0]));
      end else begin
        exp_res = setpoint_q.pop_front();
        if (out_tdata[TEMP_W-1:0] !== exp_res.temp)
          report_mismatch("target_temperature", exp_res.temp,
                          $signed(out_tdata[TEMP_W-1:0]));
        if (out_tdata[TEMP_W +: MODE_W] !== exp_res.mode)
          report_mismatch("target_mode", exp_res.mode, out_tdata[TEMP_W +: MODE_W]);
      end
    end
  end

  initial begin
    sched_cnt[0] = 0;
    sched_cnt[1] = 0;
    default_temp = DEFAULT_TEMP_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_tables();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    test_sorted_lookup();
    test_default_setpoint();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0 && setpoint_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/dssl_pkg.sv
rtl/dssl_front.sv
rtl/dssl_queue.sv
rtl/dssl_back.sv
rtl/day_schedule_setpoint_lookup.sv
rtl/dssl_checker.sv
dv/testbench.sv
